FILE: hw/rtl/nmgc_pkg.sv
package nmgc_pkg;

    localparam int MAX_WIDTH  = 32;
    localparam int MAX_HEIGHT = 32;

    localparam int CRD_W  = 5;
    localparam int DIM_W  = 6;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int DIST_W = 8;
    localparam int DATA_W = 16;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 2'd1;
    localparam logic [DIM_W-1:0]     MAP_RESET      = 6'd32;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_QUERY = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [CRD_W-1:0] x;
        logic [CRD_W-1:0] y;
        logic             mark;
    } t_cmd;

endpackage

FILE: hw/rtl/nmgc_front.sv
module nmgc_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_mode,
    input  logic [4:0]            i_x,
    input  logic [4:0]            i_y,
    input  logic                  i_mark,
    output logic                  o_cmd_valid,
    input  logic                  i_cmd_ready,
    output nmgc_pkg::t_cmd        o_cmd
);
    import nmgc_pkg::*;

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic in_grid;
    logic keep;

    // writes that fall outside the grid are dropped here
    assign in_grid = (32'(i_x) < 32'(MAX_WIDTH)) && (32'(i_y) < 32'(MAX_HEIGHT));
    assign keep    = (t_kind'(i_mode) == KIND_QUERY) || in_grid;
    assign o_ready = !r_valid || i_cmd_ready;

    always_comb begin
        n_cmd.kind = t_kind'(i_mode);
        n_cmd.x    = i_x;
        n_cmd.y    = i_y;
        n_cmd.mark = i_mark;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid && keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

endmodule

FILE: hw/rtl/nmgc_queue.sv
module nmgc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  nmgc_pkg::t_cmd i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output nmgc_pkg::t_cmd o_data
);
    import nmgc_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    logic              pop;

    assign o_ready = (r_count != QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: hw/rtl/nmgc_back.sv
module nmgc_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [nmgc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [nmgc_pkg::DIM_W-1:0]        i_cfg_data,
    input  logic                              i_cmd_valid,
    output logic                              o_cmd_ready,
    input  nmgc_pkg::t_cmd                    i_cmd,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_found,
    output logic [nmgc_pkg::CRD_W-1:0]        o_tx,
    output logic [nmgc_pkg::CRD_W-1:0]        o_ty
);
    import nmgc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_DRAIN = 3'b100
    } t_state;

    t_state r_state;

    logic [DIM_W-1:0] r_map_w;
    logic [DIM_W-1:0] r_map_h;

    logic [MAX_WIDTH-1:0]  r_rows [MAX_HEIGHT];
    logic [MAX_HEIGHT-1:0] r_row_ok;
    logic [MAX_WIDTH-1:0]  r_rd_data;
    logic                  r_rd_ok;

    logic [CRD_W-1:0] r_cx;
    logic [CRD_W-1:0] r_cy;
    logic [DIM_W-1:0] r_w;
    logic [DIM_W-1:0] r_h;
    logic [DIM_W-1:0] r_scan_row;

    logic             r_s1_act;
    logic [ROW_W-1:0] r_s1_row;

    logic              r_s2_act;
    logic              r_s2_hit;
    logic [COL_W-1:0]  r_s2_x;
    logic [ROW_W-1:0]  r_s2_y;
    logic [DIST_W-1:0] r_s2_d;

    logic              r_found;
    logic [COL_W-1:0]  r_best_x;
    logic [ROW_W-1:0]  r_best_y;
    logic [DIST_W-1:0] r_best_d;

    logic             r_out_valid;
    logic             r_out_found;
    logic [CRD_W-1:0] r_out_x;
    logic [CRD_W-1:0] r_out_y;

    logic                 take;
    logic                 wr_en;
    logic [ROW_W-1:0]     wr_row;
    logic [MAX_WIDTH-1:0] wr_onehot;
    logic [MAX_WIDTH-1:0] wr_mask;
    logic [MAX_WIDTH-1:0] wr_bits;
    logic [ROW_W-1:0]     rd_row;
    logic                 s0_act;
    logic                 drain_done;
    logic                 best_upd;

    logic [MAX_WIDTH-1:0] row_bits;
    logic [MAX_WIDTH-1:0] lo_bits;
    logic [MAX_WIDTH-1:0] hi_bits;
    logic                 lo_hit;
    logic                 hi_hit;
    logic [COL_W-1:0]     lo_x;
    logic [COL_W-1:0]     hi_x;
    logic [DIST_W-1:0]    lo_dx;
    logic [DIST_W-1:0]    hi_dx;
    logic [DIST_W-1:0]    dy;
    logic                 pick_lo;
    logic [COL_W-1:0]     s1_x;
    logic [DIST_W-1:0]    s1_d;

    logic [DIM_W-1:0] w_clamp;
    logic [DIM_W-1:0] h_clamp;

    assign w_clamp = (32'(r_map_w) > 32'(MAX_WIDTH))  ? DIM_W'(MAX_WIDTH)  : r_map_w;
    assign h_clamp = (32'(r_map_h) > 32'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : r_map_h;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_w <= MAP_RESET;
            r_map_h <= MAP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAP_WIDTH:  r_map_w <= i_cfg_data;
                CFG_MAP_HEIGHT: r_map_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // commands are taken only in idle; a query needs the output register free, a write does not
    assign o_cmd_ready = (r_state == ST_IDLE) &&
                         ((i_cmd.kind == KIND_WRITE) || !r_out_valid);
    assign take        = i_cmd_valid && o_cmd_ready;
    assign wr_en       = take && (i_cmd.kind == KIND_WRITE);
    assign wr_row      = ROW_W'(i_cmd.y);
    assign wr_onehot   = MAX_WIDTH'(1) << COL_W'(i_cmd.x);
    // first write into a row that was never written clears the rest of it
    assign wr_mask     = r_row_ok[wr_row] ? wr_onehot : '1;
    assign wr_bits     = wr_onehot & {MAX_WIDTH{i_cmd.mark}};

    assign rd_row = r_scan_row[ROW_W-1:0];
    assign s0_act = (r_state == ST_SCAN) && (r_scan_row < r_h);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            for (int i = 0; i < MAX_WIDTH; i++) begin
                if (wr_mask[i]) begin
                    r_rows[wr_row][i] <= wr_bits[i];
                end
            end
        end
        r_rd_data <= r_rows[rd_row];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_ok <= '0;
        end else if (wr_en) begin
            r_row_ok[wr_row] <= 1'b1;
        end
    end

    // stage 1: nearest marked column in the row, ties to the lower column
    always_comb begin
        row_bits = '0;
        lo_bits  = '0;
        hi_bits  = '0;
        for (int i = 0; i < MAX_WIDTH; i++) begin
            row_bits[i] = r_rd_ok && r_rd_data[i] && (i < int'(r_w));
            lo_bits[i]  = row_bits[i] && (i <= int'(r_cx));
            hi_bits[i]  = row_bits[i] && (i > int'(r_cx));
        end
    end

    always_comb begin
        lo_hit = 1'b0;
        lo_x   = '0;
        for (int i = 0; i < MAX_WIDTH; i++) begin
            if (lo_bits[i]) begin
                lo_hit = 1'b1;
                lo_x   = COL_W'(i);
            end
        end
    end

    always_comb begin
        hi_hit = 1'b0;
        hi_x   = '0;
        for (int i = MAX_WIDTH - 1; i >= 0; i--) begin
            if (hi_bits[i]) begin
                hi_hit = 1'b1;
                hi_x   = COL_W'(i);
            end
        end
    end

    always_comb begin
        lo_dx   = DIST_W'(r_cx) - DIST_W'(lo_x);
        hi_dx   = DIST_W'(hi_x) - DIST_W'(r_cx);
        dy      = (DIST_W'(r_s1_row) > DIST_W'(r_cy)) ?
                  DIST_W'(r_s1_row) - DIST_W'(r_cy) : DIST_W'(r_cy) - DIST_W'(r_s1_row);
        pick_lo = lo_hit && (!hi_hit || (lo_dx <= hi_dx));
        s1_x    = pick_lo ? lo_x : hi_x;
        s1_d    = (pick_lo ? lo_dx : hi_dx) + dy;
    end

    assign best_upd = r_s2_act && r_s2_hit &&
                      (!r_found || (r_s2_d < r_best_d) ||
                       ((r_s2_d == r_best_d) && (r_s2_x < r_best_x)));

    assign drain_done = (r_state == ST_DRAIN) && !r_s1_act && !r_s2_act;

    always_ff @(posedge i_clk) begin
        r_s1_row <= rd_row;
        r_rd_ok  <= r_row_ok[rd_row];
        r_s2_hit <= lo_hit || hi_hit;
        r_s2_x   <= s1_x;
        r_s2_y   <= r_s1_row;
        r_s2_d   <= s1_d;
        if (take && (i_cmd.kind == KIND_QUERY)) begin
            r_cx <= i_cmd.x;
            r_cy <= i_cmd.y;
            r_w  <= w_clamp;
            r_h  <= h_clamp;
        end
        if (drain_done) begin
            r_out_found <= r_found;
            r_out_x     <= CRD_W'(r_best_x);
            r_out_y     <= CRD_W'(r_best_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_scan_row  <= '0;
            r_s1_act    <= 1'b0;
            r_s2_act    <= 1'b0;
            r_found     <= 1'b0;
            r_best_x    <= '0;
            r_best_y    <= '0;
            r_best_d    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_act <= s0_act;
            r_s2_act <= r_s1_act;
            if (drain_done) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (best_upd) begin
                r_found  <= 1'b1;
                r_best_x <= r_s2_x;
                r_best_y <= r_s2_y;
                r_best_d <= r_s2_d;
            end
            case (r_state)
                ST_IDLE: begin
                    if (take && (i_cmd.kind == KIND_QUERY)) begin
                        r_scan_row <= '0;
                        r_found    <= 1'b0;
                        r_best_x   <= '0;
                        r_best_y   <= '0;
                        r_best_d   <= '0;
                        r_state    <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (s0_act) begin
                        r_scan_row <= r_scan_row + 1'b1;
                    end else begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (drain_done) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_out_found;
    assign o_tx        = r_out_x;
    assign o_ty        = r_out_y;

`ifndef SYNTHESIS
    a_out_from_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_DRAIN))
        else $error("result raised outside drain");
    a_query_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && (i_cmd.kind == KIND_QUERY)) |-> !r_out_valid)
        else $error("query started with result pending");
    a_none_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |-> ((r_out_x == '0) && (r_out_y == '0)))
        else $error("empty result with nonzero coordinates");
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_scan_row <= r_h))
        else $error("scan row past map height");
`endif

endmodule

FILE: hw/rtl/nearest_marked_grid_cell.sv
// Nearest marked grid cell search over a 32 x 32 grid of one-bit marks.
// Input stream s_axis: tuser = mode (0 write mark, 1 query); tdata carries
// cell_x, cell_y and mark_value. A write request sets or clears one mark and
// gives no result; writes outside the grid are dropped. A query request
// returns one result on m_axis: tuser = found, tdata = target_x, target_y,
// the nearest marked cell inside the map by Manhattan distance, ties to the
// smaller column and then the smaller row; coordinates are 0 when none found.
// Config port: i_cfg_we with i_cfg_idx 0 = map_width, 1 = map_height.
// Writes are taken one per cycle while the queue has room. A query scans one
// grid row per cycle in the scan state, then drains the search pipeline and
// registers its result; the search unit takes no new command until then, so
// queries never overlap.
// The input register and a two-entry command queue keep accepting requests
// while a result waits on a stalled m_axis; a query waits in the queue
// until the result register is free, and input backs up once the queue fills.
// Reset clears all marks at once through per-row valid bits (no clearing
// pass) and sets both map registers to 32.
module nearest_marked_grid_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [nmgc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [nmgc_pkg::DIM_W-1:0]      i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [nmgc_pkg::DATA_W-1:0]     s_axis_tdata,  // cell_x[4:0], cell_y[9:5], mark_value[10]
    input  logic [0:0]                      s_axis_tuser,  // mode[0]
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [nmgc_pkg::DATA_W-1:0]     m_axis_tdata,  // target_x[4:0], target_y[9:5]
    output logic [0:0]                      m_axis_tuser   // found[0]
);
    import nmgc_pkg::*;

    logic             f_valid;
    logic             f_ready;
    t_cmd             f_cmd;
    logic             q_valid;
    logic             q_ready;
    t_cmd             q_cmd;
    logic             found;
    logic [CRD_W-1:0] tx;
    logic [CRD_W-1:0] ty;

    nmgc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_mode      (s_axis_tuser[0]),
        .i_x         (s_axis_tdata[CRD_W-1:0]),
        .i_y         (s_axis_tdata[2*CRD_W-1:CRD_W]),
        .i_mark      (s_axis_tdata[2*CRD_W]),
        .o_cmd_valid (f_valid),
        .i_cmd_ready (f_ready),
        .o_cmd       (f_cmd)
    );

    nmgc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  (f_cmd),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_cmd)
    );

    nmgc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (q_valid),
        .o_cmd_ready (q_ready),
        .i_cmd       (q_cmd),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_found     (found),
        .o_tx        (tx),
        .o_ty        (ty)
    );

    assign m_axis_tdata = {(DATA_W - 2*CRD_W)'(0), ty, tx};
    assign m_axis_tuser = found;

endmodule

FILE: tb/testbench.sv
module testbench;
    import nmgc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam int N_PHASES       = 10;
    localparam int ITEMS_PER_PHASE = 120;
    localparam int QUIET_CYCLES   = 60;
    localparam int LONG_HOLD      = 300;

    typedef struct packed {
        logic             found;
        logic [CRD_W-1:0] tx;
        logic [CRD_W-1:0] ty;
    } t_nearest;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [DIM_W-1:0]     i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [DATA_W-1:0]    s_axis_tdata = '0;
    logic [0:0]           s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [DATA_W-1:0]    m_axis_tdata;
    logic [0:0]           m_axis_tuser;

    // predictor state
    bit       grid_marks [0:MAX_WIDTH-1][0:MAX_HEIGHT-1];
    int       map_w = int'(MAP_RESET);
    int       map_h = int'(MAP_RESET);

    t_cmd     pending_cmds[$];
    t_nearest expected_hits[$];
    int       queued_count = 0;
    int       accepted_count = 0;
    int       mismatches = 0;
    bit       idle_on = 1'b1;
    int       mark_pct = 50;

    nearest_marked_grid_cell dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int draw_wait();
        if (!idle_on || $urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 19);
    endfunction

    function automatic int used_cols();
        return map_w > MAX_WIDTH ? MAX_WIDTH : map_w;
    endfunction

    function automatic int used_rows();
        return map_h > MAX_HEIGHT ? MAX_HEIGHT : map_h;
    endfunction

    // Manhattan nearest; columns then rows ascending, strict improvement keeps ties
    function automatic t_nearest find_nearest(input logic [CRD_W-1:0] qx,
                                              input logic [CRD_W-1:0] qy);
        t_nearest best;
        int       w, h, d, best_d, cx, cy;
        w = used_cols();
        h = used_rows();
        cx = int'(qx);
        cy = int'(qy);
        best = '0;
        best_d = 0;
        for (int x = 0; x < w; x++) begin
            for (int y = 0; y < h; y++) begin
                if (grid_marks[x][y]) begin
                    d = (x > cx ? x - cx : cx - x) + (y > cy ? y - cy : cy - y);
                    if (!best.found || d < best_d) begin
                        best.found = 1'b1;
                        best_d = d;
                        best.tx = CRD_W'(x);
                        best.ty = CRD_W'(y);
                    end
                end
            end
        end
        return best;
    endfunction

    function automatic t_cmd random_cmd();
        t_cmd c;
        int   w, h;
        w = used_cols();
        h = used_rows();
        c.kind = $urandom_range(0, 1) ? KIND_QUERY : KIND_WRITE;
        if (w > 0 && h > 0 && $urandom_range(0, 9) < 7) begin
            c.x = CRD_W'($urandom_range(0, w - 1));
            c.y = CRD_W'($urandom_range(0, h - 1));
        end else begin
            c.x = CRD_W'($urandom_range(0, MAX_WIDTH - 1));
            c.y = CRD_W'($urandom_range(0, MAX_HEIGHT - 1));
        end
        c.mark = ($urandom_range(0, 99) < mark_pct);
        return c;
    endfunction

    task automatic queue_cmd(input t_kind k, input logic [CRD_W-1:0] x,
                             input logic [CRD_W-1:0] y, input logic m);
        t_cmd c;
        c.kind = k;
        c.x = x;
        c.y = y;
        c.mark = m;
        pending_cmds.push_back(c);
        queued_count++;
    endtask

    task automatic wait_quiet();
        while (accepted_count != queued_count || expected_hits.size() != 0)
            @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_map_reg(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [DIM_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_MAP_WIDTH)
            map_w = int'(val);
        else if (idx == CFG_MAP_HEIGHT)
            map_h = int'(val);
    endtask

    // request driver
    always @(posedge i_clk) begin : send_side
        int   send_gap;
        t_cmd nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap = 0;
        end else if (!(s_axis_tvalid && !s_axis_tready)) begin
            if (send_gap > 0) begin
                s_axis_tvalid <= 1'b0;
                send_gap = send_gap - 1;
            end else if (pending_cmds.size() > 0) begin
                nxt = pending_cmds.pop_front();
                s_axis_tdata <= {5'b0, nxt.mark, nxt.y, nxt.x};
                s_axis_tuser <= nxt.kind;
                s_axis_tvalid <= 1'b1;
                send_gap = draw_wait();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result receiver; long hold-offs let the block back up
    always @(posedge i_clk) begin : recv_side
        int rx_wait;
        int rx_count;
        int w;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait = 0;
            rx_count = 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            rx_count = rx_count + 1;
            w = (rx_count == 40 || rx_count == 400) ? LONG_HOLD : draw_wait();
            m_axis_tready <= (w == 0);
            rx_wait = w;
        end else if (rx_wait > 0) begin
            rx_wait = rx_wait - 1;
            m_axis_tready <= (rx_wait == 0);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // checker and predictor
    always @(posedge i_clk) begin : check_side
        t_nearest got, want;
        logic [CRD_W-1:0] ax, ay;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.found = m_axis_tuser[0];
                got.tx = m_axis_tdata[4:0];
                got.ty = m_axis_tdata[9:5];
                if (expected_hits.size() == 0) begin
                    $display("%0t unexpected result: found %0d x %0d y %0d",
                             $time, got.found, got.tx, got.ty);
                    mismatches++;
                end else begin
                    want = expected_hits.pop_front();
                    if (got.found !== want.found) begin
                        $display("%0t found: expected %0d actual %0d",
                                 $time, want.found, got.found);
                        mismatches++;
                    end
                    if (got.tx !== want.tx) begin
                        $display("%0t target_x: expected %0d actual %0d",
                                 $time, want.tx, got.tx);
                        mismatches++;
                    end
                    if (got.ty !== want.ty) begin
                        $display("%0t target_y: expected %0d actual %0d",
                                 $time, want.ty, got.ty);
                        mismatches++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                accepted_count++;
                ax = s_axis_tdata[4:0];
                ay = s_axis_tdata[9:5];
                if (t_kind'(s_axis_tuser[0]) == KIND_WRITE)
                    grid_marks[ax][ay] = s_axis_tdata[10];
                else
                    expected_hits.push_back(find_nearest(ax, ay));
            end
        end
    end

    initial begin : main_seq
        int               phase_w [0:N_PHASES-1];
        int               phase_h [0:N_PHASES-1];
        logic [DIM_W-1:0] w_val, h_val;
        t_cmd             c;
        phase_w = '{32, 1, 0, 63, 33, 1, 32, 5, 32, 0};
        phase_h = '{32, 1, 32, 63, 40, 32, 1, 9, 0, 0};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // unused register indexes must not touch the map size
        write_map_reg(CFG_SPARE_A, '0);
        write_map_reg(CFG_SPARE_B, '0);

        // empty grid, far corners, self hit, column and row ties, clears
        queue_cmd(KIND_QUERY, 5'd0, 5'd0, 1'b0);
        queue_cmd(KIND_QUERY, 5'd31, 5'd31, 1'b1);
        queue_cmd(KIND_WRITE, 5'd31, 5'd31, 1'b1);
        queue_cmd(KIND_QUERY, 5'd0, 5'd0, 1'b0);
        queue_cmd(KIND_WRITE, 5'd0, 5'd31, 1'b1);
        queue_cmd(KIND_QUERY, 5'd0, 5'd0, 1'b0);
        queue_cmd(KIND_WRITE, 5'd5, 5'd5, 1'b1);
        queue_cmd(KIND_QUERY, 5'd5, 5'd5, 1'b0);
        queue_cmd(KIND_WRITE, 5'd3, 5'd7, 1'b1);
        queue_cmd(KIND_WRITE, 5'd7, 5'd3, 1'b1);
        queue_cmd(KIND_WRITE, 5'd5, 5'd5, 1'b0);
        queue_cmd(KIND_QUERY, 5'd5, 5'd5, 1'b0);
        queue_cmd(KIND_WRITE, 5'd9, 5'd3, 1'b1);
        queue_cmd(KIND_WRITE, 5'd9, 5'd7, 1'b1);
        queue_cmd(KIND_QUERY, 5'd9, 5'd5, 1'b0);
        queue_cmd(KIND_WRITE, 5'd31, 5'd0, 1'b1);
        queue_cmd(KIND_QUERY, 5'd31, 5'd0, 1'b0);
        queue_cmd(KIND_QUERY, 5'd16, 5'd16, 1'b1);
        queue_cmd(KIND_WRITE, 5'd31, 5'd31, 1'b0);
        queue_cmd(KIND_WRITE, 5'd0, 5'd31, 1'b0);
        queue_cmd(KIND_WRITE, 5'd3, 5'd7, 1'b0);
        queue_cmd(KIND_WRITE, 5'd7, 5'd3, 1'b0);
        queue_cmd(KIND_WRITE, 5'd9, 5'd3, 1'b0);
        queue_cmd(KIND_WRITE, 5'd9, 5'd7, 1'b0);
        queue_cmd(KIND_WRITE, 5'd31, 5'd0, 1'b0);
        queue_cmd(KIND_QUERY, 5'd10, 5'd10, 1'b0);

        for (int p = 0; p < N_PHASES; p++) begin
            wait_quiet();
            if (p == N_PHASES - 1) begin
                w_val = DIM_W'($urandom_range(0, 63));
                h_val = DIM_W'($urandom_range(0, 63));
            end else begin
                w_val = DIM_W'(phase_w[p]);
                h_val = DIM_W'(phase_h[p]);
            end
            write_map_reg(CFG_MAP_WIDTH, w_val);
            write_map_reg(CFG_MAP_HEIGHT, h_val);
            idle_on = (p % 3 != 1);
            mark_pct = (p % 2) ? 25 : 65;
            repeat (ITEMS_PER_PHASE) begin
                c = random_cmd();
                queue_cmd(c.kind, c.x, c.y, c.mark);
            end
        end

        wait_quiet();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin : watchdog
        #5000000;
        $display("FAILURE");
        $finish;
    end

endmodule
